// ----- hw/rtl/mpfd_pkg.sv -----
package mpfd_pkg;

   localparam int DEF_WIDTH  = 128;
   localparam int DEF_HEIGHT = 64;
   localparam int FIFO_DEPTH = 2;

   localparam logic [7:0] BYTE_ONES = 8'hff;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef enum logic [1:0] {OP_FILL, OP_POINT, OP_LINE, OP_READ} op_type;
   typedef enum logic [1:0] {PEN_SET, PEN_CLR, PEN_INV} pen_type;
   typedef enum logic [1:0] {KIND_FILL, KIND_WALK, KIND_READ} kind_type;

   // Decoded command handed from the front end to the sequencer.
   typedef struct packed {
      kind_type   kind;
      pen_type    pen;
      logic [7:0] x1;        // start column, or read column
      logic [7:0] y1;        // start row, or read page
      logic [7:0] span;      // steps after the first pixel
      logic       col_move;  // walk runs along columns
      logic       col_dec;
      logic       row_dec;   // vertical walk goes up
      logic       slope;     // needs the step divide
      logic       s_neg;     // slope is negative
      logic [7:0] dx_abs;
      logic [7:0] s_abs;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_DFIX, ST_PIX, ST_WR,
      ST_FRD, ST_FWR, ST_RREQ, ST_RDATA
   } state_type;

endpackage

// ----- hw/rtl/mpfd_ram.sv -----
module mpfd_ram #(
   parameter int DataWidth = 8,
   parameter int Depth     = 1024,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AddrWidth-1:0] waddr,
   input  logic [DataWidth-1:0] wdata,
   input  logic                 re,
   input  logic [AddrWidth-1:0] raddr,
   output logic [DataWidth-1:0] rdata
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/mpfd_front.sv -----
module mpfd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [1:0]        req_pen,
   input  logic [7:0]        req_first_x,
   input  logic [7:0]        req_first_y,
   input  logic [7:0]        req_second_x,
   input  logic [7:0]        req_second_y,
   input  logic              hold,
   output logic              cmd_valid,
   output mpfd_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import mpfd_pkg::*;

   localparam int PtrW = $clog2(FIFO_DEPTH);

   cmd_type        dec;
   logic [7:0]     dx_abs, dy_abs;
   logic           x_back, y_back;
   logic           push;
   cmd_type        fifo_ff [FIFO_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]  cnt_ff;

   always_comb begin
      x_back = req_second_x < req_first_x;
      y_back = req_second_y < req_first_y;
      dx_abs = x_back ? req_first_x - req_second_x : req_second_x - req_first_x;
      dy_abs = y_back ? req_first_y - req_second_y : req_second_y - req_first_y;

      dec    = '0;
      dec.x1 = req_first_x;
      dec.y1 = req_first_y;
      case (pen_type'(req_pen))
         PEN_SET: dec.pen = PEN_SET;
         PEN_CLR: dec.pen = PEN_CLR;
         default: dec.pen = PEN_INV;
      endcase
      case (op_type'(req_operation))
         OP_FILL:  dec.kind = KIND_FILL;
         OP_POINT: dec.kind = KIND_WALK;
         OP_LINE: begin
            dec.kind = KIND_WALK;
            if (dy_abs == 8'd0 || dx_abs != 8'd0) begin
               // horizontal or sloped: one pixel per column
               dec.span     = dx_abs;
               dec.col_move = 1'b1;
               dec.col_dec  = x_back;
               dec.slope    = dy_abs != 8'd0;
               // row moves toward second_y whichever way the columns run
               dec.s_neg    = y_back;
               dec.dx_abs   = dx_abs;
               dec.s_abs    = dy_abs;
            end else begin
               dec.span    = dy_abs;
               dec.row_dec = y_back;
            end
         end
         default: dec.kind = KIND_READ;
      endcase
   end

   assign req_ready = (cnt_ff != (PtrW+1)'(FIFO_DEPTH)) && !hold;
   assign push      = req_valid && req_ready;
   assign cmd_valid = cnt_ff != '0;
   assign cmd       = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, cmd_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ----- hw/rtl/mpfd_back.sv -----
module mpfd_back #(
   parameter int Width  = mpfd_pkg::DEF_WIDTH,
   parameter int Height = mpfd_pkg::DEF_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mpfd_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              hold,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_byte
);
   import mpfd_pkg::*;

   localparam int Pages = (Height + 7) / 8;
   localparam int Depth = Pages * Width;
   localparam int AW    = $clog2(Depth);

   state_type     state_ff, state_in;
   cmd_type       cmd_ff;
   logic [7:0]    cnt_ff, col_ff, r_ff, step_r_ff;
   logic [9:0]    row_ff, step_q_ff;   // two's complement
   logic [7:0]    div_rem_ff, div_quo_ff;
   logic [2:0]    div_cnt_ff;
   logic [AW-1:0] idx_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;

   logic          on_screen, walk_last, idx_last, rd_ok, carry, div_ge, rsp_load;
   logic [AW-1:0] pix_addr, rd_addr;
   logic [7:0]    mask, pix_data, fill_data, col_next, r_next, rem_new;
   logic [8:0]    r_sum, rem_sh;
   logic [9:0]    row_next;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_q;

   always_comb begin
      on_screen = !row_ff[9] && (row_ff < 10'(Height)) && (col_ff < 8'(Width));
      walk_last = cnt_ff == cmd_ff.span;
      idx_last  = idx_ff == AW'(Depth - 1);
      pix_addr  = AW'(32'(row_ff[9:3]) * Width + 32'(col_ff));
      rd_ok     = (cmd_ff.x1 < 8'(Width)) && (cmd_ff.y1 < 8'(Pages));
      rd_addr   = AW'(32'(cmd_ff.y1) * Width + 32'(cmd_ff.x1));
      mask      = 8'd1 << row_ff[2:0];

      case (cmd_ff.pen)
         PEN_SET: begin
            pix_data  = ram_q | mask;
            fill_data = BYTE_ONES;
         end
         PEN_CLR: begin
            pix_data  = ram_q & ~mask;
            fill_data = BYTE_ZERO;
         end
         default: begin
            pix_data  = ram_q ^ mask;
            fill_data = ~ram_q;
         end
      endcase

      // incremental floor: row advances by the quotient, plus one on remainder wrap
      r_sum    = {1'b0, r_ff} + {1'b0, step_r_ff};
      carry    = cmd_ff.slope && (r_sum >= {1'b0, cmd_ff.dx_abs});
      r_next   = carry ? 8'(r_sum - {1'b0, cmd_ff.dx_abs}) : r_sum[7:0];
      row_next = row_ff + step_q_ff + {9'd0, carry};
      col_next = cmd_ff.col_move ? (cmd_ff.col_dec ? col_ff - 8'd1 : col_ff + 8'd1)
                                 : col_ff;

      rem_sh  = {div_rem_ff, div_quo_ff[7]};
      div_ge  = rem_sh >= {1'b0, cmd_ff.dx_abs};
      rem_new = div_ge ? 8'(rem_sh - {1'b0, cmd_ff.dx_abs}) : rem_sh[7:0];

      rsp_load = (state_ff == ST_RDATA) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (idx_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  KIND_FILL: state_in = ST_FRD;
                  KIND_READ: state_in = ST_RREQ;
                  default:   state_in = cmd.slope ? ST_DIV : ST_PIX;
               endcase
            end
         end
         ST_DIV:  if (div_cnt_ff == 3'd7) state_in = ST_DFIX;
         ST_DFIX: state_in = ST_PIX;
         ST_PIX: begin
            if (on_screen)      state_in = ST_WR;
            else if (walk_last) state_in = ST_IDLE;
         end
         ST_WR:    if (walk_last) state_in = ST_IDLE; else state_in = ST_PIX;
         ST_FRD:   state_in = ST_FWR;
         ST_FWR:   state_in = idx_last ? ST_IDLE : ST_FRD;
         ST_RREQ:  state_in = ST_RDATA;
         ST_RDATA: if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      hold      = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = BYTE_ZERO;
      ram_re    = 1'b0;
      ram_raddr = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            hold   = 1'b1;
            ram_we = 1'b1;
         end
         ST_IDLE: cmd_pop = cmd_valid;
         ST_PIX: begin
            ram_re    = on_screen;
            ram_raddr = pix_addr;
         end
         ST_WR: begin
            ram_we    = 1'b1;
            ram_waddr = pix_addr;
            ram_wdata = pix_data;
         end
         ST_FRD: ram_re = 1'b1;
         ST_FWR: begin
            ram_we    = 1'b1;
            ram_wdata = fill_data;
         end
         ST_RREQ: begin
            ram_re    = rd_ok;
            ram_raddr = rd_addr;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR, ST_FWR: idx_ff <= idx_ff + 1'b1;
            ST_IDLE:          idx_ff <= '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_byte_ff <= rd_ok ? ram_q : BYTE_ZERO;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ff     <= cmd;
               cnt_ff     <= 8'd0;
               col_ff     <= cmd.x1;
               row_ff     <= {2'b00, cmd.y1};
               r_ff       <= 8'd0;
               step_r_ff  <= 8'd0;
               step_q_ff  <= cmd.col_move ? 10'd0 : (cmd.row_dec ? '1 : 10'd1);
               div_rem_ff <= 8'd0;
               div_quo_ff <= cmd.s_abs;
               div_cnt_ff <= 3'd0;
            end
         end
         ST_DIV: begin
            div_rem_ff <= rem_new;
            div_quo_ff <= {div_quo_ff[6:0], div_ge};
            div_cnt_ff <= div_cnt_ff + 3'd1;
         end
         ST_DFIX: begin
            // floor of a negative slope: -(q+1) with remainder d-r when inexact
            if (cmd_ff.s_neg) begin
               step_q_ff <= 10'd0 - ({2'b00, div_quo_ff} + {9'd0, div_rem_ff != 8'd0});
               step_r_ff <= (div_rem_ff != 8'd0) ? cmd_ff.dx_abs - div_rem_ff : 8'd0;
            end else begin
               step_q_ff <= {2'b00, div_quo_ff};
               step_r_ff <= div_rem_ff;
            end
         end
         ST_PIX, ST_WR: begin
            if ((state_ff == ST_WR || !on_screen) && !walk_last) begin
               cnt_ff <= cnt_ff + 8'd1;
               col_ff <= col_next;
               row_ff <= row_next;
               r_ff   <= r_next;
            end
         end
         default: ;
      endcase
   end

   mpfd_ram #(
      .DataWidth(8),
      .Depth    (Depth)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_q)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

endmodule

// ----- hw/rtl/mono_page_framebuffer_draw_unit.sv -----
// Page-organized monochrome framebuffer (WIDTH columns by ceil(HEIGHT/8) byte pages) with
// fill, point, line and byte-read commands. Requests land in a two-entry command queue
// and run one at a time against the byte store, which is read and then written for each
// touched byte: a fill rewrites every byte, a point or line rewrites the byte of each
// on-screen pixel and skips clipped pixels, and a sloped line first runs a step divide.
// A read returns its byte on rsp_; other requests return nothing.
// After reset the store is cleared while req_ready stays low.
module mono_page_framebuffer_draw_unit #(
   parameter int WIDTH  = mpfd_pkg::DEF_WIDTH,
   parameter int HEIGHT = mpfd_pkg::DEF_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [1:0] req_pen,
   input  logic [7:0] req_first_x,
   input  logic [7:0] req_first_y,
   input  logic [7:0] req_second_x,
   input  logic [7:0] req_second_y,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_byte
);
   import mpfd_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_pop, hold;

   mpfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_pen      (req_pen),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .hold         (hold),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   mpfd_back #(
      .Width (WIDTH),
      .Height(HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .hold         (hold),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_read_byte(rsp_read_byte)
   );

endmodule

// ----- hw/rtl/mpfd_checker.sv -----
module mpfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_operation,
   input logic [1:0] req_pen,
   input logic [7:0] req_first_x,
   input logic [7:0] req_first_y,
   input logic [7:0] req_second_x,
   input logic [7:0] req_second_y,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte
);

   // store clear runs right after reset, so req_ready stays low while it runs
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_ready ##1 !req_ready)
      else $error("request accepted during store clear");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte))
      else $error("stalled response dropped or changed");

endmodule

bind mono_page_framebuffer_draw_unit mpfd_checker u_mpfd_checker (.*);

// ----- verif/testbench.sv -----
class fb_scoreboard;
   logic [7:0] pixels [0:1023];
   logic [7:0] pending_bytes [$];
   int errors;
   int reads_checked;
   int line_count;
   int fill_count;
   int point_count;

   function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      errors = 0;
      reads_checked = 0;
      line_count = 0;
      fill_count = 0;
      point_count = 0;
   endfunction

   function void plot(int x, int y, logic [1:0] pen);
      int idx;
      logic [7:0] mask;
      if (x < 0 || y < 0 || x >= 128 || y >= 64) return;
      idx = (y / 8) * 128 + x;
      mask = 8'h01 << (y % 8);
      if (pen == mpfd_pkg::PEN_SET) pixels[idx] = pixels[idx] | mask;
      else if (pen == mpfd_pkg::PEN_CLR) pixels[idx] = pixels[idx] & ~mask;
      else pixels[idx] = pixels[idx] ^ mask;
   endfunction

   function int floor_quot(int n, int d);
      int q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   function void note_request(logic [1:0] op, logic [1:0] pen, int x1, int y1, int x2, int y2);
      int lo;
      int hi;
      int row;
      case (op)
         mpfd_pkg::OP_FILL: begin
            fill_count++;
            foreach (pixels[i]) begin
               if (pen == mpfd_pkg::PEN_SET) pixels[i] = 8'hff;
               else if (pen == mpfd_pkg::PEN_CLR) pixels[i] = 8'h00;
               else pixels[i] = ~pixels[i];
            end
         end
         mpfd_pkg::OP_POINT: begin
            point_count++;
            plot(x1, y1, pen);
         end
         mpfd_pkg::OP_LINE: begin
            line_count++;
            lo = (x1 < x2) ? x1 : x2;
            hi = (x1 < x2) ? x2 : x1;
            if (y1 == y2) begin
               for (int i = lo; i <= hi; i++) plot(i, y1, pen);
            end else if (x1 == x2) begin
               lo = (y1 < y2) ? y1 : y2;
               hi = (y1 < y2) ? y2 : y1;
               for (int i = lo; i <= hi; i++) plot(x1, i, pen);
            end else begin
               for (int i = lo; i <= hi; i++) begin
                  row = y1 + floor_quot((i - x1) * (y2 - y1), x2 - x1);
                  if (row >= 0) plot(i, row, pen);
               end
            end
         end
         default: begin
            if (x1 < 128 && y1 < 8) pending_bytes.push_back(pixels[y1 * 128 + x1]);
            else pending_bytes.push_back(8'h00);
         end
      endcase
   endfunction

   function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
         $display("%0t: read byte %h with no read pending", $time, got);
         errors++;
         return;
      end
      want = pending_bytes.pop_front();
      reads_checked++;
      if (got !== want) begin
         $display("%0t: read_byte expected %h got %h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module testbench;
   import mpfd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = 2'd0;
   logic [1:0] req_pen = 2'd0;
   logic [7:0] req_first_x = 8'd0;
   logic [7:0] req_first_y = 8'd0;
   logic [7:0] req_second_x = 8'd0;
   logic [7:0] req_second_y = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_read_byte;
   int stall_mode = 0;

   fb_scoreboard board = new();

   mono_page_framebuffer_draw_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_pen(req_pen),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_byte(rsp_read_byte)
   );

   always #4 clock = ~clock;

   // receiver: phases of no stall, light stall and heavy stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_byte(rsp_read_byte);
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_request(logic [1:0] op, logic [1:0] pen,
                               logic [7:0] x1, logic [7:0] y1,
                               logic [7:0] x2, logic [7:0] y2);
      req_valid <= 1'b1;
      req_operation <= op;
      req_pen <= pen;
      req_first_x <= x1;
      req_first_y <= y1;
      req_second_x <= x2;
      req_second_y <= y2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, pen, x1, y1, x2, y2);
   endtask

   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_random();
      int pick;
      logic [1:0] op;
      logic [7:0] x1, y1, x2, y2;
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_FILL;
      else if (pick < 35) op = OP_POINT;
      else if (pick < 60) op = OP_LINE;
      else op = OP_READ;
      // mostly on-screen coordinates, some anywhere
      x1 = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127));
      y1 = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63));
      x2 = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127));
      y2 = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63));
      if (op == OP_LINE && $urandom_range(0, 3) == 0) y2 = y1;
      else if (op == OP_LINE && $urandom_range(0, 3) == 0) x2 = x1;
      if (op == OP_READ && $urandom_range(0, 9) != 0) y1 = 8'($urandom_range(0, 7));
      send_request(op, 2'($urandom_range(0, 3)), x1, y1, x2, y2);
   endtask

   initial begin
      int sent;
      int burst;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_READ, PEN_SET, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(OP_POINT, PEN_SET, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(OP_POINT, PEN_SET, 8'd127, 8'd63, 8'd0, 8'd0);
      send_request(OP_POINT, PEN_SET, 8'd128, 8'd5, 8'd0, 8'd0);
      send_request(OP_POINT, PEN_SET, 8'd5, 8'd64, 8'hff, 8'hff);
      send_request(OP_POINT, 2'd3, 8'd127, 8'd63, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd127, 8'd7, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(OP_LINE, PEN_SET, 8'd120, 8'd10, 8'd3, 8'd10);
      send_request(OP_LINE, PEN_INV, 8'd7, 8'd7, 8'd7, 8'd7);
      send_request(OP_LINE, PEN_SET, 8'd9, 8'd60, 8'd9, 8'd2);
      send_request(OP_LINE, PEN_CLR, 8'd0, 8'd63, 8'd127, 8'd0);
      send_request(OP_LINE, 2'd3, 8'd250, 8'd255, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd9, 8'd3, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd128, 8'd0, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd0, 8'd8, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'hff, 8'hff, 8'hff, 8'hff);
      send_request(OP_FILL, PEN_SET, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd64, 8'd4, 8'd0, 8'd0);
      send_request(OP_FILL, PEN_INV, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(OP_POINT, PEN_INV, 8'd64, 8'd33, 8'd0, 8'd0);
      send_request(OP_READ, PEN_SET, 8'd64, 8'd4, 8'd0, 8'd0);
      send_request(OP_FILL, 2'd3, 8'd0, 8'd0, 8'd0, 8'd0);
      send_request(OP_FILL, PEN_CLR, 8'd0, 8'd0, 8'd0, 8'd0);
      idle_gap(1);

      // drain fully once before the random part
      while (board.pending_bytes.size() != 0) @(posedge clock);

      sent = 0;
      while (sent < 550) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            send_random();
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      idle_gap(1);
      while (board.pending_bytes.size() != 0) @(posedge clock);
      repeat (2500) @(posedge clock);

      $display("covered %0d fills, %0d points, %0d lines, %0d reads checked",
               board.fill_count, board.point_count, board.line_count, board.reads_checked);
      if (board.errors == 0 && board.pending_bytes.size() == 0) begin
         $display("mono_page_framebuffer_draw_unit test passed");
      end else begin
         $display("mono_page_framebuffer_draw_unit test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("mono_page_framebuffer_draw_unit test failed");
      $finish;
   end
endmodule
